/* rtl/core/bpsc_pkg.sv */
// Byte pattern search counter: shared constants, register indexes and helpers.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bpsc_pkg;

  // Fixed widths of the item fields and registers
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned PAT_BYTES   = 16;   // bytes held by the two pattern words
  localparam int unsigned PLEN_W      = 5;
  localparam int unsigned OUT_COUNT_W = 16;
  localparam int unsigned CFG_IDX_W   = 3;

  // Parameter defaults
  localparam int unsigned MAX_PATTERN_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  // Text-mode byte limits
  localparam logic [BYTE_W-1:0] TEXT_LO = 8'h05;
  localparam logic [BYTE_W-1:0] TEXT_HI = 8'h7f;

  // ASCII upper-case range
  localparam logic [BYTE_W-1:0] UPPER_A   = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z   = 8'h5a;
  localparam logic [BYTE_W-1:0] CASE_STEP = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO    = 3'd0,
    REG_PAT_HI    = 3'd1,
    REG_PAT_LEN   = 3'd2,
    REG_FOLD_CASE = 3'd3,
    REG_COUNT_ALL = 3'd4,
    REG_TEXT_ONLY = 3'd5
  } cfg_reg_t;

  typedef logic [BYTE_W-1:0] byte_t;

  // Lower-case an ASCII letter when folding is on
  function automatic byte_t fold_byte(input byte_t c, input logic en);
    byte_t r;
    r = c;
    if (en && (c >= UPPER_A) && (c <= UPPER_Z)) begin
      r = c + CASE_STEP;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bpsc_match.sv */
// Window comparator: checks the newest len bytes against the pattern.
// Depends on bpsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpsc_match #(
  parameter int unsigned MAX_PATTERN = bpsc_pkg::MAX_PATTERN_DEF,
  parameter int unsigned LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic [MAX_PATTERN-1:0][bpsc_pkg::BYTE_W-1:0] win,     // entry 0 newest
  input  wire logic [bpsc_pkg::WORD_W-1:0]                   pat_lo,
  input  wire logic [bpsc_pkg::WORD_W-1:0]                   pat_hi,
  input  wire logic [LEN_W-1:0]                              len,
  input  wire logic                                          fold_en,
  output logic                                               hit
);
  import bpsc_pkg::*;

  logic [PAT_BYTES-1:0][BYTE_W-1:0] pat;
  logic [MAX_PATTERN-1:0]           pos_ok;
  logic [PLEN_W-1:0]                len5;

  assign pat  = {pat_hi, pat_lo};
  assign len5 = PLEN_W'(len);

  // Window entry j lines up with pattern byte len-1-j
  always_comb begin
    logic [PLEN_W-1:0] k5;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      k5 = len5 - PLEN_W'(1) - PLEN_W'(j);
      pos_ok[j] = (PLEN_W'(j) >= len5) ||
                  (fold_byte(pat[k5[3:0]], fold_en) == fold_byte(win[j], fold_en));
    end
  end

  assign hit = &pos_ok;

endmodule

`default_nettype wire

/* rtl/core/byte_pattern_search_counter_unit.sv */
// Byte pattern search counter, top level: config registers, pipeline, search state.
// Depends on bpsc_pkg and bpsc_match.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | direction | handshake           | payload
// in_      | input     | in_valid / in_stall | in_data_byte, in_buffer_end
// out_     | output    | out_valid/out_stall | out_match_ends_here, out_matches_so_far,
//          |           |                     | out_search_over
// cfg_     | input     | cfg_we              | cfg_index, cfg_wdata
//
// One item per cycle sustained while out_stall is low; an accepted item goes to the
// input register, then compare + state update write the result register, from
// which it can be taken.
// The window compare against the pattern is combinational.
// rst_n (synchronous, active low) clears control, search state, config; length is 1.
// A stall on out_ holds the result; the input register fills, then in_stall rises.

module byte_pattern_search_counter_unit #(
  parameter int unsigned MAX_PATTERN = bpsc_pkg::MAX_PATTERN_DEF,
  parameter int unsigned COUNT_BITS  = bpsc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input items
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [bpsc_pkg::BYTE_W-1:0]      in_data_byte,
  input  wire logic                             in_buffer_end,
  // result items
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_match_ends_here,
  output logic [bpsc_pkg::OUT_COUNT_W-1:0]      out_matches_so_far,
  output logic                                  out_search_over,
  // configuration writes
  input  wire logic                             cfg_we,
  input  wire logic [bpsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bpsc_pkg::WORD_W-1:0]      cfg_wdata
);
  import bpsc_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

  // ---------------- configuration registers ----------------
  logic [WORD_W-1:0] pat_lo_r, pat_hi_r;
  logic [PLEN_W-1:0] plen_r;
  logic              fold_r, count_all_r, text_only_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r    <= '0;
      pat_hi_r    <= '0;
      plen_r      <= PLEN_W'(1);
      fold_r      <= 1'b0;
      count_all_r <= 1'b0;
      text_only_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAT_LO:    pat_lo_r    <= cfg_wdata;
        REG_PAT_HI:    pat_hi_r    <= cfg_wdata;
        REG_PAT_LEN:   plen_r      <= cfg_wdata[PLEN_W-1:0];
        REG_FOLD_CASE: fold_r      <= cfg_wdata[0];
        REG_COUNT_ALL: count_all_r <= cfg_wdata[0];
        REG_TEXT_ONLY: text_only_r <= cfg_wdata[0];
        default: ;  // unused index: ignored
      endcase
    end
  end

  // Active length: zero acts as one, clipped to MAX_PATTERN
  logic [LEN_W-1:0] len;
  always_comb begin
    if (plen_r == '0) begin
      len = LEN_W'(1);
    end else if (plen_r > PLEN_W'(MAX_PATTERN)) begin
      len = LEN_W'(MAX_PATTERN);
    end else begin
      len = LEN_W'(plen_r);
    end
  end

  // ---------------- pipeline control ----------------
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic              out_valid_r;
  logic              out_ready;
  logic              s1_advance;

  assign out_ready  = !out_valid_r || !out_stall;
  assign s1_advance = s1_valid_r && out_ready;
  assign in_stall   = s1_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_buffer_end;
    end
  end

  // ---------------- search state ----------------
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] recent_r, recent_nxt;
  logic [LEN_W-1:0]                   seen_r, seen_nxt;
  logic [LEN_W-1:0]                   cool_r, cool_nxt;
  logic [COUNT_BITS-1:0]              total_r, total_nxt;
  logic                               ended_r, ended_nxt;

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] win;
  logic                               win_hit;
  logic                               text_bad;

  // Window as it stands once this byte is shifted in
  always_comb begin
    win[0] = s1_byte_r;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win[i] = recent_r[i-1];
    end
  end

  bpsc_match #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W)
  ) u_match (
    .win     (win),
    .pat_lo  (pat_lo_r),
    .pat_hi  (pat_hi_r),
    .len     (len),
    .fold_en (fold_r),
    .hit     (win_hit)
  );

  assign text_bad = text_only_r && ((s1_byte_r < TEXT_LO) || (s1_byte_r > TEXT_HI));

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] recent_upd;
  logic [LEN_W-1:0]                   seen_upd, cool_upd;
  logic [COUNT_BITS-1:0]              total_upd;
  logic                               ended_upd;
  logic                               hit;
  logic [31:0]                        total_ext;

  always_comb begin
    recent_upd = recent_r;
    seen_upd   = seen_r;
    cool_upd   = cool_r;
    total_upd  = total_r;
    ended_upd  = ended_r;
    hit        = 1'b0;
    if (!ended_r) begin
      if (text_bad) begin
        ended_upd = 1'b1;
      end else begin
        recent_upd = win;
        if (seen_r < LEN_W'(MAX_PATTERN)) begin
          seen_upd = seen_r + LEN_W'(1);
        end
        if (cool_r != '0) begin
          cool_upd = cool_r - LEN_W'(1);
        end
        // cooldown keeps matches from sharing bytes
        if ((cool_r == '0) && (seen_upd >= len) && win_hit) begin
          hit = 1'b1;
          if (total_r != '1) begin
            total_upd = total_r + COUNT_BITS'(1);
          end
          cool_upd = len - LEN_W'(1);
          if (!count_all_r) begin
            ended_upd = 1'b1;
          end
        end
      end
    end
    // buffer end: everything starts over for the next buffer
    if (s1_last_r) begin
      recent_nxt = '0;
      seen_nxt   = '0;
      cool_nxt   = '0;
      total_nxt  = '0;
      ended_nxt  = 1'b0;
    end else begin
      recent_nxt = recent_upd;
      seen_nxt   = seen_upd;
      cool_nxt   = cool_upd;
      total_nxt  = total_upd;
      ended_nxt  = ended_upd;
    end
  end

  assign total_ext = 32'(total_upd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= '0;
      seen_r   <= '0;
      cool_r   <= '0;
      total_r  <= '0;
      ended_r  <= 1'b0;
    end else if (s1_advance) begin
      recent_r <= recent_nxt;
      seen_r   <= seen_nxt;
      cool_r   <= cool_nxt;
      total_r  <= total_nxt;
      ended_r  <= ended_nxt;
    end
  end

  // ---------------- result register ----------------
  logic                   res_hit_r;
  logic [OUT_COUNT_W-1:0] res_count_r;
  logic                   res_over_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res_hit_r   <= hit;
      res_count_r <= total_ext[OUT_COUNT_W-1:0];
      res_over_r  <= ended_upd || s1_last_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_match_ends_here = res_hit_r;
  assign out_matches_so_far  = res_count_r;
  assign out_search_over     = res_over_r;

endmodule

`default_nettype wire

/* rtl/core/bpsc_checker.sv */
// Port-level checks for the byte pattern search counter, bound to the top level.
// Depends on bpsc_pkg and byte_pattern_search_counter_unit.
`timescale 1ns / 1ps
`default_nettype none

module bpsc_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic                             out_match_ends_here,
  input wire logic [bpsc_pkg::OUT_COUNT_W-1:0] out_matches_so_far,
  input wire logic                             out_search_over
);
  import bpsc_pkg::*;

  logic                   in_acc, out_acc;
  logic [2:0]             occ_r;
  logic                   prev_ok_r;
  logic [OUT_COUNT_W-1:0] prev_count_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // items inside the block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_r + 3'(in_acc) - 3'(out_acc);
    end
  end

  // last delivered result of a buffer still in progress
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ok_r <= 1'b0;
    end else if (out_acc) begin
      prev_ok_r <= !out_search_over;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_count_r <= out_matches_so_far;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_matches_so_far) &&
      $stable(out_match_ends_here) && $stable(out_search_over))
    else $error("result changed while stalled");

  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r <= 3'd2) && !(out_valid && occ_r == 3'd0))
    else $error("result without item, or too many items held");

  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match_ends_here |-> out_matches_so_far != '0)
    else $error("match flagged with zero count");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && prev_ok_r |->
      (out_matches_so_far == prev_count_r) ||
      (out_matches_so_far == prev_count_r + OUT_COUNT_W'(1)))
    else $error("count moved by more than one within a buffer");

endmodule

bind byte_pattern_search_counter_unit bpsc_checker u_bpsc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_match_ends_here (out_match_ends_here),
  .out_matches_so_far  (out_matches_so_far),
  .out_search_over     (out_search_over)
);

`default_nettype wire
